// ===== sv/bfha_pkg.sv =====
// Package: types and constants for the best-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;
	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_BITS  = 24;
	localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
	localparam logic [23:0] ARENA_RESET  = 24'd10485760;
	localparam logic [6:0]  HEADER_RESET = 7'd32;
	localparam logic [23:0] LEN_MAX      = 24'hFFFFFF;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_ZERO = 3'd1, ST_NOSPACE = 3'd2,
		ST_FULL = 3'd3, ST_UNKNOWN = 3'd4, ST_NULL = 3'd5
	} status_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam logic CFG_ARENA  = 1'b0;
	localparam logic CFG_HEADER = 1'b1;

	typedef struct packed {
		logic        action;
		logic [23:0] request_size;
		logic [23:0] payload_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] granted_address;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [23:0]          length;
		logic                 free;
	} entry_t;
endpackage
`default_nettype wire

// ===== sv/best_fit_heap_allocator.sv =====
// Top level: best-fit heap allocator with a block table in one synchronous memory.
`timescale 1ns / 1ps
`default_nettype none
// Command-style allocator. Pulse start while busy is low with an allocate or a free
// item; exactly one result appears for one cycle with done high, in the same cycle
// that busy drops, and the receiver cannot stall it. The block table (start, length,
// free) lives in one single-port-write, registered-read memory of MAX_BLOCKS entries,
// so every allocate or free, other than a zero-size or null request, walks the table
// one entry per cycle: a scan (best fit or address match) and a decision, then for a
// split or a merge a shift of the entries above it, each a read then a write. A free
// that merges on both sides shifts twice, which is the worst case. The worst allocate
// is a split of entry 0 with 63 entries. Zero-size and null requests skip the scan
// and go straight to the finish state. Configuration writes (index 0 arena_bytes,
// 1 header_bytes) are accepted whenever cfg_valid is high; cfg_ready is always high,
// and that the host writes only while idle is its own duty, which the block itself
// does not enforce. No clearing pass: only entries below the count are used.
module best_fit_heap_allocator (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire bfha_pkg::req_t   req,
	output logic                  busy,
	output logic                  done,
	output bfha_pkg::rsp_t        rsp,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [0:0]            cfg_index,
	input  wire  [23:0]           cfg_data
);
	import bfha_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_RD_HIT, S_OPEN_RD, S_OPEN_WR, S_SPLIT_WR,
		S_NB_RD, S_NB_CHK, S_CLOSE_RD, S_CLOSE_WR, S_FINISH
	} state_t;

	state_t                state_q;
	entry_t                mem [MAX_BLOCKS];
	entry_t                rd_q;
	logic [IDX_BITS-1:0]   rd_addr;
	logic                  we;
	logic [IDX_BITS-1:0]   wr_addr;
	entry_t                wr_data;

	logic [23:0]           arena_q;
	logic [6:0]            header_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [ADDR_BITS-1:0]  top_q;
	req_t                  req_q;

	logic [CNT_BITS-1:0]   scan_q;     // entry whose data arrives in rd_q
	logic                  found_q;
	logic [IDX_BITS-1:0]   best_q;
	entry_t                best_e_q;
	logic [CNT_BITS-1:0]   ptr_q;      // shift pointer
	entry_t                hold_q;     // entry carried through merges
	logic [1:0]            phase_q;    // 0 merge right, 1 merge left
	logic [2:0]            st_q;
	logic [23:0]           grant_q;
	logic                  wb_q;       // FINISH writes hold_q back at best_q

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q  <= ARENA_RESET;
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index[0])
				CFG_ARENA:  arena_q  <= cfg_data;
				CFG_HEADER: header_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Derived values
	logic [24:0] spare;
	logic [25:0] top_end;
	logic [25:0] merged;
	logic [23:0] merged_len;
	logic        scan_match;
	assign spare   = {1'b0, best_e_q.length} - {1'b0, req_q.request_size};
	assign top_end = {2'b0, top_q} + {19'b0, header_q} + {2'b0, req_q.request_size};
	assign scan_match = req_q.action == ACT_FREE
		? ((rd_q.start + ADDR_BITS'(header_q)) == req_q.payload_address)
		: (rd_q.free && rd_q.length >= req_q.request_size &&
		   (!found_q || rd_q.length < best_e_q.length));
	// same sum for either neighbour; saturates at the length width
	assign merged = {2'b0, hold_q.length} + {19'b0, header_q} + {2'b0, rd_q.length};
	assign merged_len = (merged[25:24] != 2'b00) ? LEN_MAX : merged[23:0];

	// Memory port control
	always_comb begin
		rd_addr = '0; we = 1'b0; wr_addr = '0; wr_data = hold_q;
		unique case (state_q)
			S_IDLE:     rd_addr = '0;
			S_SCAN:     rd_addr = scan_q[IDX_BITS-1:0] + IDX_BITS'(1);
			S_OPEN_RD:  rd_addr = ptr_q[IDX_BITS-1:0] - IDX_BITS'(1);
			S_OPEN_WR: begin
				we = 1'b1; wr_addr = ptr_q[IDX_BITS-1:0]; wr_data = rd_q;
			end
			S_SPLIT_WR: begin
				we = 1'b1; wr_addr = best_q + IDX_BITS'(1);
				wr_data.start  = best_e_q.start + ADDR_BITS'(req_q.request_size)
					+ ADDR_BITS'(header_q);
				wr_data.length = spare[23:0] - 24'(header_q);
				wr_data.free   = 1'b1;
			end
			S_RD_HIT: begin
				we = 1'b1; wr_addr = best_q; wr_data = hold_q;
			end
			S_NB_RD: rd_addr = (phase_q == 2'd0) ? best_q + IDX_BITS'(1)
				: best_q - IDX_BITS'(1);
			S_CLOSE_RD: rd_addr = ptr_q[IDX_BITS-1:0] + IDX_BITS'(1);
			S_CLOSE_WR: begin
				we = 1'b1; wr_addr = ptr_q[IDX_BITS-1:0]; wr_data = rd_q;
			end
			S_FINISH: begin
				we = wb_q; wr_addr = best_q; wr_data = hold_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; count_q <= '0; top_q <= '0; done <= 1'b0;
			rsp <= '0; found_q <= 1'b0; req_q <= '0; scan_q <= '0;
			best_q <= '0; best_e_q <= '0; ptr_q <= '0; hold_q <= '0;
			phase_q <= '0; st_q <= ST_OK; grant_q <= '0; wb_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					req_q <= req; scan_q <= '0; found_q <= 1'b0; grant_q <= '0;
					wb_q <= 1'b0;
					if (req.action == ACT_ALLOC && req.request_size == 24'd0) begin
						st_q <= ST_ZERO; state_q <= S_FINISH;
					end else if (req.action == ACT_FREE && req.payload_address == '0) begin
						st_q <= ST_NULL; state_q <= S_FINISH;
					end else begin
						state_q <= (count_q != '0) ? S_SCAN : S_DECIDE;
					end
				end
				S_SCAN: begin
					if (scan_match && !(req_q.action == ACT_FREE && found_q)) begin
						found_q <= 1'b1; best_q <= scan_q[IDX_BITS-1:0]; best_e_q <= rd_q;
					end
					if (scan_q + CNT_BITS'(1) >= count_q) state_q <= S_DECIDE;
					scan_q <= scan_q + CNT_BITS'(1);
				end
				S_DECIDE: begin
					if (req_q.action == ACT_FREE) begin
						if (!found_q) begin
							st_q <= ST_UNKNOWN; state_q <= S_FINISH;
						end else begin
							st_q <= ST_OK; wb_q <= 1'b1;
							hold_q <= '{start: best_e_q.start, length: best_e_q.length,
								free: 1'b1};
							phase_q <= 2'd0; state_q <= S_RD_HIT;
						end
					end else if (found_q) begin
						st_q    <= ST_OK;
						wb_q    <= 1'b1;
						grant_q <= best_e_q.start + ADDR_BITS'(header_q);
						if (spare > {18'b0, header_q} && count_q < CNT_BITS'(MAX_BLOCKS)) begin
							hold_q <= '{start: best_e_q.start, length: req_q.request_size,
								free: 1'b0};
							ptr_q <= count_q; state_q <= S_OPEN_RD;
						end else begin
							hold_q <= '{start: best_e_q.start, length: best_e_q.length,
								free: 1'b0};
							state_q <= S_FINISH;
						end
					end else if (top_end > {2'b0, arena_q}) begin
						st_q <= ST_NOSPACE; state_q <= S_FINISH;
					end else if (count_q >= CNT_BITS'(MAX_BLOCKS)) begin
						st_q <= ST_FULL; state_q <= S_FINISH;
					end else begin
						st_q <= ST_OK; grant_q <= top_q + ADDR_BITS'(header_q);
						wb_q <= 1'b1;
						best_q <= count_q[IDX_BITS-1:0];
						hold_q <= '{start: top_q, length: req_q.request_size, free: 1'b0};
						count_q <= count_q + CNT_BITS'(1);
						top_q <= top_end[ADDR_BITS-1:0];
						state_q <= S_FINISH;
					end
				end
				S_OPEN_RD: state_q <= (ptr_q > CNT_BITS'(best_q) + CNT_BITS'(1))
					? S_OPEN_WR : S_SPLIT_WR;
				S_OPEN_WR: begin
					ptr_q <= ptr_q - CNT_BITS'(1); state_q <= S_OPEN_RD;
				end
				S_SPLIT_WR: begin
					count_q <= count_q + CNT_BITS'(1); state_q <= S_FINISH;
				end
				S_RD_HIT: begin
					// hit written back as free; check right neighbour, then left
					if (phase_q == 2'd0 && CNT_BITS'(best_q) + CNT_BITS'(1) < count_q)
						state_q <= S_NB_RD;
					else if (phase_q == 2'd0 && best_q != '0) begin
						phase_q <= 2'd1; state_q <= S_NB_RD;
					end else if (phase_q == 2'd1 && best_q != '0) state_q <= S_NB_RD;
					else state_q <= S_FINISH;
				end
				S_NB_RD: state_q <= S_NB_CHK;
				S_NB_CHK: begin
					if (rd_q.free) begin
						if (phase_q == 2'd0) begin
							hold_q <= '{start: hold_q.start, length: merged_len, free: 1'b1};
							ptr_q <= CNT_BITS'(best_q) + CNT_BITS'(1);
						end else begin
							hold_q <= '{start: rd_q.start, length: merged_len, free: 1'b1};
							ptr_q <= CNT_BITS'(best_q);
							best_q <= best_q - IDX_BITS'(1);
						end
						state_q <= S_CLOSE_RD;
					end else if (phase_q == 2'd0 && best_q != '0) begin
						phase_q <= 2'd1; state_q <= S_NB_RD;
					end else state_q <= S_FINISH;
				end
				S_CLOSE_RD: begin
					if (ptr_q + CNT_BITS'(1) < count_q) state_q <= S_CLOSE_WR;
					else begin
						count_q <= count_q - CNT_BITS'(1);
						state_q <= (phase_q == 2'd0) ? S_RD_HIT : S_FINISH;
						phase_q <= 2'd1;
					end
				end
				S_CLOSE_WR: begin
					ptr_q <= ptr_q + CNT_BITS'(1); state_q <= S_CLOSE_RD;
				end
				S_FINISH: begin
					done <= 1'b1;
					rsp <= '{status: st_q,
						granted_address: (st_q == ST_OK) ? grant_q : 24'd0};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_done_one;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	assert property (p_done_one) else $error("done held two cycles");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_BLOCKS)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !$past(busy)) |-> $past(start)) else $error("spurious start");
endmodule
`default_nettype wire

// ===== tb/sv/tb_best_fit_heap_allocator.sv =====
// Testbench: best-fit heap allocator, directed table then random phases with a self-checking predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_best_fit_heap_allocator;
	import bfha_pkg::*;

	localparam int IDLE_LIMIT = 5000;          // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 3 * MAX_BLOCKS + 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	req_t        req = '0;
	logic        busy;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	best_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Heap shadow: address-ordered block table, top pointer, registers
	// ---------------------------------------------------------------
	logic [23:0] blk_start [MAX_BLOCKS];
	logic [23:0] blk_len   [MAX_BLOCKS];
	logic        blk_free  [MAX_BLOCKS];
	int          blk_count = 0;
	logic [23:0] heap_end = '0;
	logic [23:0] arena_sz = ARENA_RESET;
	logic [6:0]  hdr_sz = HEADER_RESET;

	rsp_t grants_due [$];                      // expected results, oldest first
	int   fails = 0;
	int   n_items = 0;
	int   n_checked = 0;
	int   n_cfg = 0;
	int   status_seen [8];
	int   burst_left = 0;

	function automatic void drop_entry(int at);
		for (int i = at; i + 1 < blk_count; i++) begin
			blk_start[i] = blk_start[i + 1];
			blk_len[i]   = blk_len[i + 1];
			blk_free[i]  = blk_free[i + 1];
		end
		blk_count--;
	endfunction

	function automatic logic [23:0] sat24(logic [63:0] v);
		return (v > 64'(LEN_MAX)) ? LEN_MAX : v[23:0];
	endfunction

	function automatic rsp_t heap_alloc(logic [23:0] size);
		rsp_t        o;
		int          best;
		logic [63:0] spare;
		logic [63:0] fin;
		o = '0;
		best = -1;
		if (size == '0) begin
			o.status = ST_ZERO;
			return o;
		end
		for (int i = 0; i < blk_count; i++)
			if (blk_free[i] && blk_len[i] >= size && (best < 0 || blk_len[i] < blk_len[best]))
				best = i;
		if (best >= 0) begin
			spare = 64'(blk_len[best]) - 64'(size);
			// split only when the leftover can carry its own header
			if (spare > 64'(hdr_sz) && blk_count < MAX_BLOCKS) begin
				for (int i = blk_count; i > best + 1; i--) begin
					blk_start[i] = blk_start[i - 1];
					blk_len[i]   = blk_len[i - 1];
					blk_free[i]  = blk_free[i - 1];
				end
				blk_count++;
				blk_start[best + 1] = blk_start[best] + size + 24'(hdr_sz);
				blk_len[best + 1]   = 24'(spare - 64'(hdr_sz));
				blk_free[best + 1]  = 1'b1;
				blk_len[best]       = size;
			end
			blk_free[best] = 1'b0;
			o.status = ST_OK;
			o.granted_address = blk_start[best] + 24'(hdr_sz);
			return o;
		end
		fin = 64'(heap_end) + 64'(hdr_sz) + 64'(size);
		if (fin > 64'(arena_sz))
			o.status = ST_NOSPACE;
		else if (blk_count >= MAX_BLOCKS)
			o.status = ST_FULL;
		else begin
			blk_start[blk_count] = heap_end;
			blk_len[blk_count]   = size;
			blk_free[blk_count]  = 1'b0;
			blk_count++;
			o.status = ST_OK;
			o.granted_address = heap_end + 24'(hdr_sz);
			heap_end = fin[23:0];
		end
		return o;
	endfunction

	function automatic rsp_t heap_release(logic [23:0] addr);
		rsp_t o;
		int   hit;
		o = '0;
		hit = -1;
		if (addr == '0) begin
			o.status = ST_NULL;
			return o;
		end
		for (int i = 0; i < blk_count && hit < 0; i++)
			if (blk_start[i] + 24'(hdr_sz) == addr)
				hit = i;
		if (hit < 0) begin
			o.status = ST_UNKNOWN;
			return o;
		end
		blk_free[hit] = 1'b1;
		if (hit + 1 < blk_count && blk_free[hit + 1]) begin
			blk_len[hit] = sat24(64'(blk_len[hit]) + 64'(hdr_sz) + 64'(blk_len[hit + 1]));
			drop_entry(hit + 1);
		end
		if (hit > 0 && blk_free[hit - 1]) begin
			blk_len[hit - 1] = sat24(64'(blk_len[hit - 1]) + 64'(hdr_sz) + 64'(blk_len[hit]));
			drop_entry(hit);
		end
		o.status = ST_OK;
		return o;
	endfunction

	function automatic rsp_t heap_apply(req_t r);
		return (r.action == ACT_ALLOC) ? heap_alloc(r.request_size)
			: heap_release(r.payload_address);
	endfunction

	// ---------------------------------------------------------------
	// Result checker: the receiver cannot stall, so every done is taken
	// ---------------------------------------------------------------
	rsp_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				$error("result with nothing pending: status %0d addr %h",
					rsp.status, rsp.granted_address);
				fails++;
			end else begin
				want = grants_due.pop_front();
				n_checked++;
				status_seen[rsp.status]++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, rsp.status);
					fails++;
				end
				if (rsp.granted_address !== want.granted_address) begin
					$error("granted_address: expected %h actual %h",
						want.granted_address, rsp.granted_address);
					fails++;
				end
			end
		end
	end

	// watchdog: counts cycles with no handshake of any kind
	int quiet = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet >= IDLE_LIMIT) begin
			$display("[best_fit_heap_allocator] ERROR");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		int p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			burst_left = $urandom_range(8, 40);  // a stretch back to back
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// start stays high into the next item when there is no gap
	task automatic send_item(req_t r, bit typed, rsp_t typed_rsp);
		int   gap;
		rsp_t e;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		e = heap_apply(r);
		grants_due.push_back(typed ? typed_rsp : e);
		n_items++;
	endtask

	// wait until the block is idle with nothing pending
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [23:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ARENA)
			arena_sz = val;
		else
			hdr_sz = val[6:0];
		n_cfg++;
	endtask

	function automatic req_t rand_item(int alloc_pct);
		req_t r;
		int   p;
		r.action = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
		r.request_size = 24'($urandom);        // unused field still toggles
		r.payload_address = 24'($urandom);
		p = $urandom_range(0, 99);
		if (r.action == ACT_ALLOC) begin
			if (p < 5)       r.request_size = '0;
			else if (p < 80) r.request_size = 24'($urandom_range(1, 300));
			else if (p < 92) r.request_size = 24'($urandom_range(301, 5000));
		end else begin
			if (p < 5)
				r.payload_address = '0;
			else if (p >= 12 && blk_count > 0) begin
				p = $urandom_range(0, blk_count - 1);
				r.payload_address = blk_start[p] + 24'(hdr_sz);
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		req_t        r;
		bit          typed;
		rsp_t        o;
		logic [0:0]  idx;
		logic [23:0] val;
	} row_t;

	row_t plan [$];

	function automatic row_t item_row(logic act, logic [23:0] size, logic [23:0] addr);
		row_t w;
		w.kind = ROW_ITEM;
		w.r.action = act;
		w.r.request_size = size;
		w.r.payload_address = addr;
		w.typed = 1'b0;
		w.o = '0;
		w.idx = '0;
		w.val = '0;
		return w;
	endfunction

	function automatic row_t known_row(logic act, logic [23:0] size, logic [23:0] addr,
			status_t st, logic [23:0] ga);
		row_t w;
		w = item_row(act, size, addr);
		w.typed = 1'b1;
		w.o.status = st;
		w.o.granted_address = ga;
		return w;
	endfunction

	function automatic row_t cfg_row(logic [0:0] idx, logic [23:0] val);
		row_t w;
		w = item_row(ACT_ALLOC, '0, '0);
		w.kind = ROW_CFG;
		w.idx = idx;
		w.val = val;
		return w;
	endfunction

	typedef struct {
		logic [23:0] arena;
		logic [6:0]  hdr;
		int          alloc_pct;
		int          n;
	} phase_t;

	phase_t phases [6];

	initial begin
		req_t r;
		rsp_t none;
		none = '0;
		// reset defaults: arena 10 MiB, header 32
		plan.push_back(known_row(ACT_FREE, 24'h000005, 24'h000000, ST_NULL, '0));
		plan.push_back(known_row(ACT_ALLOC, 24'h000000, 24'h0000AB, ST_ZERO, '0));
		plan.push_back(known_row(ACT_FREE, '0, 24'h000123, ST_UNKNOWN, '0));
		plan.push_back(known_row(ACT_ALLOC, 24'hFFFFFF, '0, ST_NOSPACE, '0));
		plan.push_back(known_row(ACT_ALLOC, 24'd100, '0, ST_OK, 24'd32));
		plan.push_back(known_row(ACT_ALLOC, 24'd200, '0, ST_OK, 24'd164));
		plan.push_back(known_row(ACT_ALLOC, 24'd50, '0, ST_OK, 24'd396));
		plan.push_back(known_row(ACT_FREE, '0, 24'd164, ST_OK, '0));
		plan.push_back(item_row(ACT_ALLOC, 24'd100, '0));   // split of the freed block
		plan.push_back(item_row(ACT_ALLOC, 24'd40, '0));    // near fit, no split
		plan.push_back(item_row(ACT_FREE, '0, 24'd164));
		plan.push_back(item_row(ACT_FREE, '0, 24'd164));    // double free
		plan.push_back(item_row(ACT_FREE, '0, 24'd32));     // merge with next
		plan.push_back(item_row(ACT_FREE, '0, 24'd396));
		plan.push_back(item_row(ACT_FREE, '0, 24'd296));    // merge both sides
		plan.push_back(cfg_row(CFG_ARENA, 24'd0));
		plan.push_back(known_row(ACT_ALLOC, 24'h001000, '0, ST_NOSPACE, '0));
		plan.push_back(cfg_row(CFG_ARENA, 24'hFFFFFF));
		plan.push_back(cfg_row(CFG_HEADER, 24'd0));         // header of zero
		plan.push_back(item_row(ACT_ALLOC, 24'h800000, '0));
		plan.push_back(item_row(ACT_ALLOC, 24'h7FFE01, '0)); // top lands 64 below the end
		plan.push_back(cfg_row(CFG_HEADER, 24'd64));        // header grows at run time
		plan.push_back(item_row(ACT_FREE, '0, 24'd510));
		plan.push_back(item_row(ACT_FREE, '0, 24'h8001FE)); // merged length saturates
		plan.push_back(item_row(ACT_ALLOC, 24'hFFFFFF, '0));

		phases[0] = '{ARENA_RESET, 7'd32, 60, 95};
		phases[1] = '{24'd4096, 7'd8, 65, 95};
		phases[2] = '{24'hFFFFFF, 7'd1, 75, 95};
		phases[3] = '{24'd0, 7'd64, 50, 90};
		phases[4] = '{24'hFFFFFF, 7'd0, 60, 95};
		phases[5] = '{24'd2000, 7'd17, 55, 95};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				cfg_write(plan[i].idx, plan[i].val);
			else
				send_item(plan[i].r, plan[i].typed, plan[i].o);
		end

		// fill the table with one-byte appends until it reports full
		cfg_write(CFG_HEADER, 24'd0);
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			r.action = ACT_ALLOC;
			r.request_size = 24'd1;
			r.payload_address = 24'($urandom);
			send_item(r, 1'b0, none);
		end

		foreach (phases[p]) begin
			cfg_write(CFG_ARENA, phases[p].arena);
			cfg_write(CFG_HEADER, 24'(phases[p].hdr));
			for (int k = 0; k < phases[p].n; k++)
				send_item(rand_item(phases[p].alloc_pct), 1'b0, none);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d items, %0d results checked, %0d register writes", n_items,
			n_checked, n_cfg);
		$display("statuses ok/zero/nospace/full/unknown/null: %0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5]);
		if (fails == 0 && grants_due.size() == 0)
			$display("[best_fit_heap_allocator] OK");
		else
			$display("[best_fit_heap_allocator] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
